// ===== rtl/euclid_travel_time_heuristic_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euclidean travel-time heuristic
// Short forms for clocked assertions that the block's top-level file uses.
// ----------------------------------------------------------------------------
`ifndef EUCLID_TRAVEL_TIME_HEURISTIC_ASSERT_SVH
`define EUCLID_TRAVEL_TIME_HEURISTIC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETTH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/etth_pkg.sv =====
// ----------------------------------------------------------------------------
// Euclidean travel-time heuristic package
// Widths, register codes, reset values and word types shared by the block.
// ----------------------------------------------------------------------------
package etth_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DIST_FRAC_BITS = 8;

    localparam int OUT_W       = 24;
    localparam int MODE_W      = 2;
    localparam int SPM_W       = 16;
    localparam int SPM_FRAC    = 12;
    localparam int OVR_W       = 16;
    localparam int OVR_FRAC    = 8;
    localparam int AMP_W       = 15;
    localparam int SAVE_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_REM_W   = AMP_W + 1;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ZERO   = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_OVER   = 2'd2,
        MODE_HEIGHT = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 3'd0,
        CFG_SPM  = 3'd1,
        CFG_OVR  = 3'd2,
        CFG_AMP  = 3'd3,
        CFG_SAVE = 3'd4
    } t_cfg_idx;

    localparam t_mode              RST_MODE = MODE_PLAIN;
    localparam logic [SPM_W-1:0]  RST_SPM  = 16'd2458;
    localparam logic [OVR_W-1:0]  RST_OVR  = 16'd256;
    localparam logic [AMP_W-1:0]  RST_AMP  = 15'd100;
    localparam logic [SAVE_W-1:0] RST_SAVE = 16'd0;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] estimate_seconds;
        logic             saturated;
    } t_out_word;

    // Result decided before the divider; bypass means the divider is ignored.
    typedef struct packed {
        logic             bypass;
        logic             sat;
        logic [OUT_W-1:0] value;
    } t_pass;

endpackage

// ===== rtl/euclid_travel_time_heuristic.sv =====
// ----------------------------------------------------------------------------
// Euclidean travel-time heuristic
// Pipelined A* cost estimate in whole seconds between two 3D points.
// ----------------------------------------------------------------------------
// The input channel takes one word of two points (i_valid, o_stall, i_word);
// the output channel gives one word of estimate and saturation flag
// (o_valid, i_stall, o_word). Every input word gives exactly one output word,
// in order. A word is moved at an edge where valid is high and stall is low.
// Throughput is one word per cycle while o_stall is low. From acceptance to
// o_valid a word passes four front stages, one square-root cell per root
// bit, three stages of scaling and mode selection, one division cell per
// output bit, and the output register.
// The registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Reset empties the pipeline and loads the register
// defaults. When the receiver stalls, a one-word skid register takes the word
// in flight and o_stall rises in the next cycle; the whole pipeline then
// holds until the receiver takes a word again.
// ----------------------------------------------------------------------------
`include "euclid_travel_time_heuristic_assert.svh"

module euclid_travel_time_heuristic #(
    parameter int DIST_FRAC_BITS = etth_pkg::DIST_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  etth_pkg::t_in_word                i_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output etth_pkg::t_out_word               o_word,
    input  logic                              i_cfg_we,
    input  logic [etth_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [etth_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CB      = etth_pkg::COORD_BITS;
    localparam int OW      = etth_pkg::OUT_W;
    localparam int AMPW    = etth_pkg::AMP_W;
    localparam int AW      = CB + 1;
    localparam int SUM_W   = 2 * AW;
    localparam int ROOT_W  = AW + DIST_FRAC_BITS;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int BPROD_W = ROOT_W + etth_pkg::SPM_W;
    localparam int BASE_W  = BPROD_W - DIST_FRAC_BITS - etth_pkg::SPM_FRAC;
    localparam int OPROD_W = BASE_W + etth_pkg::OVR_W;
    localparam int OVR2_W  = OPROD_W - etth_pkg::OVR_FRAC;
    localparam int BA_W    = BASE_W + AMPW;
    localparam int DH_W    = ((CB > AMPW + 1) ? CB : AMPW + 1) + 1;
    localparam int TH_W    = etth_pkg::SAVE_W + 1 + DH_W;
    localparam int NUM_W   = ((BA_W > TH_W) ? BA_W : TH_W) + 1;
    localparam int HI_W    = NUM_W - 1 - OW;
    localparam int CMP_W   = (HI_W > AMPW) ? HI_W : AMPW;
    localparam int DRW     = etth_pkg::DIV_REM_W;

    // Configuration registers
    etth_pkg::t_mode                r_mode;
    logic [etth_pkg::SPM_W-1:0]     r_spm;
    logic [etth_pkg::OVR_W-1:0]     r_ovr;
    logic [AMPW-1:0]                r_amp;
    logic [etth_pkg::SAVE_W-1:0]    r_save;
    logic [AMPW-1:0]                w_amp_eff;

    logic w_en;

    // Front stages
    logic                 r_s0_valid;
    etth_pkg::t_in_word   r_s0_word;
    logic signed [CB-1:0] w_pa [3];
    logic signed [CB-1:0] w_pb [3];
    logic signed [AW-1:0] w_d  [3];
    logic [AW-1:0]        n_s1_abs [3];

    logic                 r_s1_valid;
    logic [AW-1:0]        r_s1_abs [3];
    logic signed [CB-1:0] r_s1_ay;
    logic                 r_s2_valid;
    logic [SUM_W-1:0]     r_s2_sq [3];
    logic signed [CB-1:0] r_s2_ay;
    logic                 r_s3_valid;
    logic [SUM_W-1:0]     r_s3_sum;
    logic signed [CB-1:0] r_s3_ay;

    // Square-root chain
    logic                 w_q_valid [ROOT_W+1];
    logic [REM_W-1:0]     w_q_rem   [ROOT_W+1];
    logic [ROOT_W-1:0]    w_q_root  [ROOT_W+1];
    logic [RAD_W-1:0]     w_q_rad   [ROOT_W+1];
    logic signed [CB-1:0] w_q_ay    [ROOT_W+1];

    // Scaling stages
    logic [BPROD_W-1:0]     w_bprod;
    logic                   r_b_valid;
    logic [BASE_W-1:0]      r_b_base;
    logic signed [CB-1:0]   r_b_ay;
    logic [OPROD_W-1:0]     w_oprod;
    logic [BA_W-1:0]        w_ba;
    logic signed [DH_W-1:0] w_dh;
    logic signed [TH_W-1:0] w_th;
    logic                   r_m_valid;
    logic [BASE_W-1:0]      r_m_base;
    logic [OVR2_W-1:0]      r_m_ovr;
    logic [BA_W-1:0]        r_m_ba;
    logic signed [TH_W-1:0] r_m_th;

    // Selection stage
    logic signed [NUM_W-1:0] w_num;
    logic [NUM_W-1:0]        w_base_z;
    logic [NUM_W-1:0]        w_ovr_z;
    logic [NUM_W-1:0]        w_max_z;
    logic                    w_num_pos;
    logic [HI_W-1:0]         w_hi;
    logic                    w_big;
    logic [DRW-1:0]          n_d_rem;
    logic [OW-1:0]           n_d_nq;
    etth_pkg::t_pass         n_d_pass;
    logic                    r_d_valid;
    logic [DRW-1:0]          r_d_rem;
    logic [OW-1:0]           r_d_nq;
    etth_pkg::t_pass         r_d_pass;

    // Division chain
    logic            w_v_valid [OW+1];
    logic [DRW-1:0]  w_v_rem   [OW+1];
    logic [OW-1:0]   w_v_nq    [OW+1];
    etth_pkg::t_pass w_v_pass  [OW+1];

    // Output side
    etth_pkg::t_out_word w_fin;
    logic                w_last_valid;
    logic                r_out_valid;
    etth_pkg::t_out_word r_out_word;
    logic                r_skid_valid;
    etth_pkg::t_out_word r_skid_word;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= etth_pkg::RST_MODE;
            r_spm  <= etth_pkg::RST_SPM;
            r_ovr  <= etth_pkg::RST_OVR;
            r_amp  <= etth_pkg::RST_AMP;
            r_save <= etth_pkg::RST_SAVE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                etth_pkg::CFG_MODE: begin
                    r_mode <= etth_pkg::t_mode'(i_cfg_data[etth_pkg::MODE_W-1:0]);
                end
                etth_pkg::CFG_SPM: begin
                    r_spm <= i_cfg_data[etth_pkg::SPM_W-1:0];
                end
                etth_pkg::CFG_OVR: begin
                    r_ovr <= i_cfg_data[etth_pkg::OVR_W-1:0];
                end
                etth_pkg::CFG_AMP: begin
                    r_amp <= i_cfg_data[AMPW-1:0];
                end
                etth_pkg::CFG_SAVE: begin
                    r_save <= i_cfg_data[etth_pkg::SAVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // An amplitude of zero is taken as one.
    assign w_amp_eff = (r_amp == '0) ? AMPW'(1) : r_amp;

    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_b_valid  <= 1'b0;
            r_m_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_b_valid  <= w_q_valid[ROOT_W];
            r_m_valid  <= r_b_valid;
            r_d_valid  <= r_m_valid;
        end
    end

    always_comb begin
        w_pa[0] = r_s0_word.a_x;
        w_pa[1] = r_s0_word.a_y;
        w_pa[2] = r_s0_word.a_z;
        w_pb[0] = r_s0_word.b_x;
        w_pb[1] = r_s0_word.b_y;
        w_pb[2] = r_s0_word.b_z;
        for (int k = 0; k < 3; k++) begin
            w_d[k]      = AW'(w_pa[k]) - AW'(w_pb[k]);
            n_s1_abs[k] = w_d[k][AW-1] ? AW'(-w_d[k]) : AW'(w_d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_word <= i_word;
            for (int k = 0; k < 3; k++) begin
                r_s1_abs[k] <= n_s1_abs[k];
                r_s2_sq[k]  <= r_s1_abs[k] * r_s1_abs[k];
            end
            r_s1_ay  <= r_s0_word.a_y;
            r_s2_ay  <= r_s1_ay;
            r_s3_sum <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3_ay  <= r_s2_ay;
        end
    end

    // ------------------------------------------------------------------
    assign w_q_valid[0] = r_s3_valid;
    assign w_q_rem[0]   = '0;
    assign w_q_root[0]  = '0;
    assign w_q_rad[0]   = RAD_W'(r_s3_sum) << (2 * DIST_FRAC_BITS);
    assign w_q_ay[0]    = r_s3_ay;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        etth_sqrt_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_q_valid[g]),
            .i_rem   (w_q_rem[g]),
            .i_root  (w_q_root[g]),
            .i_rad   (w_q_rad[g]),
            .i_ay    (w_q_ay[g]),
            .o_valid (w_q_valid[g+1]),
            .o_rem   (w_q_rem[g+1]),
            .o_root  (w_q_root[g+1]),
            .o_rad   (w_q_rad[g+1]),
            .o_ay    (w_q_ay[g+1])
        );
    end

    // ------------------------------------------------------------------
    assign w_bprod = w_q_root[ROOT_W] * r_spm;
    assign w_oprod = r_b_base * r_ovr;
    assign w_ba    = r_b_base * w_amp_eff;
    assign w_dh    = DH_W'($signed({1'b0, w_amp_eff})) - DH_W'(r_b_ay);
    assign w_th    = $signed({1'b0, r_save}) * w_dh;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_base <= w_bprod[BPROD_W-1 -: BASE_W];
            r_b_ay   <= w_q_ay[ROOT_W];
            r_m_base <= r_b_base;
            r_m_ovr  <= w_oprod[OPROD_W-1 -: OVR2_W];
            r_m_ba   <= w_ba;
            r_m_th   <= w_th;
        end
    end

    // ------------------------------------------------------------------
    always_comb begin
        w_num     = $signed(NUM_W'(r_m_ba)) - NUM_W'(r_m_th);
        w_base_z  = NUM_W'(r_m_base);
        w_ovr_z   = NUM_W'(r_m_ovr);
        w_max_z   = NUM_W'(etth_pkg::OUT_MAX);
        w_num_pos = !w_num[NUM_W-1] && (w_num != '0);
        w_hi      = w_num[NUM_W-2:OW];
        w_big     = (CMP_W'(w_hi) >= CMP_W'(w_amp_eff));

        n_d_rem        = '0;
        n_d_nq         = '0;
        n_d_pass.bypass = 1'b1;
        n_d_pass.sat    = 1'b0;
        n_d_pass.value  = '0;

        unique case (r_mode)
            etth_pkg::MODE_ZERO: begin
            end
            etth_pkg::MODE_PLAIN: begin
                n_d_pass.sat   = (w_base_z > w_max_z);
                n_d_pass.value = n_d_pass.sat ? etth_pkg::OUT_MAX : w_base_z[OW-1:0];
            end
            etth_pkg::MODE_OVER: begin
                n_d_pass.sat   = (w_ovr_z > w_max_z);
                n_d_pass.value = n_d_pass.sat ? etth_pkg::OUT_MAX : w_ovr_z[OW-1:0];
            end
            etth_pkg::MODE_HEIGHT: begin
                if (w_num_pos && w_big) begin
                    n_d_pass.sat   = 1'b1;
                    n_d_pass.value = etth_pkg::OUT_MAX;
                end else if (w_num_pos) begin
                    n_d_pass.bypass = 1'b0;
                    n_d_rem         = DRW'(w_hi);
                    n_d_nq          = w_num[OW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rem  <= n_d_rem;
            r_d_nq   <= n_d_nq;
            r_d_pass <= n_d_pass;
        end
    end

    // ------------------------------------------------------------------
    assign w_v_valid[0] = r_d_valid;
    assign w_v_rem[0]   = r_d_rem;
    assign w_v_nq[0]    = r_d_nq;
    assign w_v_pass[0]  = r_d_pass;

    for (genvar g = 0; g < OW; g++) begin : g_div
        etth_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_amp   (w_amp_eff),
            .i_valid (w_v_valid[g]),
            .i_rem   (w_v_rem[g]),
            .i_nq    (w_v_nq[g]),
            .i_pass  (w_v_pass[g]),
            .o_valid (w_v_valid[g+1]),
            .o_rem   (w_v_rem[g+1]),
            .o_nq    (w_v_nq[g+1]),
            .o_pass  (w_v_pass[g+1])
        );
    end

    // ------------------------------------------------------------------
    assign w_last_valid           = w_v_valid[OW];
    assign w_fin.estimate_seconds = w_v_pass[OW].bypass ? w_v_pass[OW].value : w_v_nq[OW];
    assign w_fin.saturated        = w_v_pass[OW].bypass & w_v_pass[OW].sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_last_valid;
            end
        end else if (w_last_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else begin
                r_out_word <= w_fin;
            end
        end else if (w_last_valid && !r_skid_valid) begin
            r_skid_word <= w_fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    // ------------------------------------------------------------------
    `ETTH_ASSERT_SAME(a_skid_has_out, r_skid_valid, r_out_valid, "skid word without output word")
    `ETTH_ASSERT_NEXT(a_skid_fills, !r_skid_valid && r_out_valid && i_stall && w_last_valid, r_skid_valid, "stalled word was lost")
    `ETTH_ASSERT_NEXT(a_pipe_holds, r_skid_valid, r_s0_valid == $past(r_s0_valid) && r_d_valid == $past(r_d_valid), "pipeline moved while full")
    `ETTH_ASSERT_SAME(a_sat_at_max, o_valid && o_word.saturated, o_word.estimate_seconds == etth_pkg::OUT_MAX, "saturated word below maximum")

endmodule

// ===== rtl/etth_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square-root cell
// Settles one root bit: brings in two radicand bits and tries a subtraction.
// ----------------------------------------------------------------------------
module etth_sqrt_cell #(
    parameter int ROOT_W = 25
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [ROOT_W+1:0]                    i_rem,
    input  logic [ROOT_W-1:0]                    i_root,
    input  logic [2*ROOT_W-1:0]                  i_rad,
    input  logic signed [etth_pkg::COORD_BITS-1:0] i_ay,
    output logic                                 o_valid,
    output logic [ROOT_W+1:0]                    o_rem,
    output logic [ROOT_W-1:0]                    o_root,
    output logic [2*ROOT_W-1:0]                  o_rad,
    output logic signed [etth_pkg::COORD_BITS-1:0] o_ay
);

    localparam int REM_W = ROOT_W + 2;
    localparam int RAD_W = 2 * ROOT_W;

    logic                                   r_valid;
    logic [REM_W-1:0]                       r_rem;
    logic [ROOT_W-1:0]                      r_root;
    logic [RAD_W-1:0]                       r_rad;
    logic signed [etth_pkg::COORD_BITS-1:0] r_ay;

    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_fit;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [RAD_W-1:0]  n_rad;

    always_comb begin
        w_rem_sh = {i_rem[REM_W-3:0], i_rad[RAD_W-1 -: 2]};
        w_trial  = {i_root, 2'b01};
        w_fit    = (w_rem_sh >= w_trial);
        n_rem    = w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
        n_root   = {i_root[ROOT_W-2:0], w_fit};
        n_rad    = {i_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_ay   <= i_ay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_ay    = r_ay;

endmodule

// ===== rtl/etth_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// Settles one quotient bit of the height-weighted estimate.
// ----------------------------------------------------------------------------
module etth_div_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [etth_pkg::AMP_W-1:0]        i_amp,
    input  logic                              i_valid,
    input  logic [etth_pkg::DIV_REM_W-1:0]    i_rem,
    input  logic [etth_pkg::OUT_W-1:0]        i_nq,
    input  etth_pkg::t_pass                   i_pass,
    output logic                              o_valid,
    output logic [etth_pkg::DIV_REM_W-1:0]    o_rem,
    output logic [etth_pkg::OUT_W-1:0]        o_nq,
    output etth_pkg::t_pass                   o_pass
);

    localparam int RW = etth_pkg::DIV_REM_W;
    localparam int QW = etth_pkg::OUT_W;

    logic            r_valid;
    logic [RW-1:0]   r_rem;
    logic [QW-1:0]   r_nq;
    etth_pkg::t_pass r_pass;

    logic [RW-1:0] w_sh;
    logic [RW-1:0] w_div;
    logic          w_fit;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_nq;

    always_comb begin
        w_sh  = {i_rem[RW-2:0], i_nq[QW-1]};
        w_div = RW'(i_amp);
        w_fit = (w_sh >= w_div);
        n_rem = w_fit ? (w_sh - w_div) : w_sh;
        n_nq  = {i_nq[QW-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_pass <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_pass  = r_pass;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the Euclidean travel-time heuristic
// Drives pairs of 3D points through the pipeline with random gaps and
// receiver stalls. Each accepted word is scored by a local fixed-point
// predictor, and the block's results are checked in order against it. The
// register settings change between drained phases and include the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CB          = etth_pkg::COORD_BITS;
    localparam int IDX_W       = etth_pkg::CFG_IDX_W;
    localparam int DATA_W      = etth_pkg::CFG_DATA_W;
    localparam int LATENCY     = 33 + etth_pkg::COORD_BITS + etth_pkg::DIST_FRAC_BITS;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 2;

    localparam logic [IDX_W-1:0] CFG_FIRST_UNUSED = IDX_W'(etth_pkg::CFG_SAVE + 1);

    typedef logic [CB-1:0] t_coord;

    localparam t_coord COORD_TOP    = {1'b0, {(CB-1){1'b1}}};
    localparam t_coord COORD_BOTTOM = {1'b1, {(CB-1){1'b0}}};

    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_CFG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        etth_pkg::t_in_word  word;
        logic [IDX_W-1:0]    idx;
        logic [DATA_W-1:0]   data;
    } t_step;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 word_valid = 1'b0;
    logic                 in_stall;
    etth_pkg::t_in_word   in_word    = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    etth_pkg::t_out_word  res_word;
    logic                 cfg_we     = 1'b0;
    logic [IDX_W-1:0]     cfg_idx    = '0;
    logic [DATA_W-1:0]    cfg_data   = '0;

    t_step               drive_plan[$];
    etth_pkg::t_out_word expected_estimates[$];

    etth_pkg::t_mode              cur_mode = etth_pkg::RST_MODE;
    logic [etth_pkg::SPM_W-1:0]   cur_spm  = etth_pkg::RST_SPM;
    logic [etth_pkg::OVR_W-1:0]   cur_ovr  = etth_pkg::RST_OVR;
    logic [etth_pkg::AMP_W-1:0]   cur_amp  = etth_pkg::RST_AMP;
    logic [etth_pkg::SAVE_W-1:0]  cur_save = etth_pkg::RST_SAVE;

    int unsigned words_planned     = 0;
    int unsigned estimates_checked = 0;
    int unsigned mismatch_count    = 0;
    int unsigned hold_start        = 0;
    int unsigned idle_cycles       = 0;
    int unsigned gap_left          = 0;
    int unsigned stall_left        = 0;
    int unsigned hold_left         = 0;
    logic        hold_done         = 1'b0;
    logic        send_quiet        = 1'b0;
    logic        recv_quiet        = 1'b0;

    euclid_travel_time_heuristic dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (word_valid),
        .o_stall    (in_stall),
        .i_word     (in_word),
        .o_valid    (res_valid),
        .i_stall    (res_stall),
        .o_word     (res_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic etth_pkg::t_out_word estimate_travel_time(etth_pkg::t_in_word w);
        longint              dx;
        longint              dy;
        longint              dz;
        longint              base;
        longint              amp;
        longint              save;
        longint              height;
        longint              num;
        longint unsigned     sumsq;
        longint unsigned     dist_q;
        longint unsigned     raw;
        etth_pkg::t_out_word r;
        dx     = longint'($signed(w.a_x)) - longint'($signed(w.b_x));
        dy     = longint'($signed(w.a_y)) - longint'($signed(w.b_y));
        dz     = longint'($signed(w.a_z)) - longint'($signed(w.b_z));
        sumsq  = longint'(dx * dx + dy * dy + dz * dz);
        dist_q = int_sqrt(sumsq << (2 * etth_pkg::DIST_FRAC_BITS));
        base   = longint'((dist_q * cur_spm) >>
                          (etth_pkg::DIST_FRAC_BITS + etth_pkg::SPM_FRAC));
        raw    = 0;
        case (cur_mode)
            etth_pkg::MODE_ZERO: begin
                raw = 0;
            end
            etth_pkg::MODE_PLAIN: begin
                raw = base;
            end
            etth_pkg::MODE_OVER: begin
                raw = (longint'(base) * cur_ovr) >> etth_pkg::OVR_FRAC;
            end
            etth_pkg::MODE_HEIGHT: begin
                amp    = (cur_amp == 0) ? 1 : cur_amp;
                save   = cur_save;
                height = longint'($signed(w.a_y));
                num    = base * amp - save * (amp - height);
                raw    = (num > 0) ? longint'(num / amp) : 0;
            end
        endcase
        if (raw > etth_pkg::OUT_MAX) begin
            r.estimate_seconds = etth_pkg::OUT_MAX;
            r.saturated        = 1'b1;
        end else begin
            r.estimate_seconds = raw[etth_pkg::OUT_W-1:0];
            r.saturated        = 1'b0;
        end
        return r;
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx,
                                           logic [DATA_W-1:0] data);
        case (idx)
            etth_pkg::CFG_MODE: cur_mode = etth_pkg::t_mode'(data[etth_pkg::MODE_W-1:0]);
            etth_pkg::CFG_SPM:  cur_spm  = data[etth_pkg::SPM_W-1:0];
            etth_pkg::CFG_OVR:  cur_ovr  = data[etth_pkg::OVR_W-1:0];
            etth_pkg::CFG_AMP:  cur_amp  = data[etth_pkg::AMP_W-1:0];
            etth_pkg::CFG_SAVE: cur_save = data[etth_pkg::SAVE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned idle_length();
        int unsigned r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic etth_pkg::t_in_word points(t_coord ax, t_coord ay, t_coord az,
                                                  t_coord bx, t_coord by, t_coord bz);
        return {ax, ay, az, bx, by, bz};
    endfunction

    function automatic t_coord extreme_coord();
        case ($urandom_range(0, 2))
            0:       return COORD_TOP;
            1:       return COORD_BOTTOM;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic etth_pkg::t_in_word random_points();
        etth_pkg::t_in_word w;
        int unsigned        sel;
        w   = etth_pkg::t_in_word'({$urandom, $urandom, $urandom});
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            w.b_x = w.a_x + t_coord'($urandom_range(0, 64)) - t_coord'(32);
            w.b_y = w.a_y + t_coord'($urandom_range(0, 64)) - t_coord'(32);
            w.b_z = w.a_z + t_coord'($urandom_range(0, 64)) - t_coord'(32);
        end else if (sel == 3) begin
            w = points(extreme_coord(), extreme_coord(), extreme_coord(),
                       extreme_coord(), extreme_coord(), extreme_coord());
        end
        return w;
    endfunction

    task automatic plan_word(etth_pkg::t_in_word w);
        t_step s;
        s       = '0;
        s.kind  = STEP_WORD;
        s.word  = w;
        drive_plan.push_back(s);
        words_planned++;
    endtask

    task automatic plan_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        t_step s;
        s      = '0;
        s.kind = STEP_CFG;
        s.idx  = idx;
        s.data = data;
        drive_plan.push_back(s);
    endtask

    task automatic plan_pause();
        t_step s;
        s      = '0;
        s.kind = STEP_DRAIN;
        drive_plan.push_back(s);
    endtask

    task automatic plan_random_phase(int unsigned n_words, etth_pkg::t_mode m);
        logic [DATA_W-1:0] v;
        plan_pause();
        v = DATA_W'($urandom);
        v[etth_pkg::MODE_W-1:0] = m;
        plan_write(etth_pkg::CFG_MODE, v);
        case ($urandom_range(0, 5))
            0:       plan_write(etth_pkg::CFG_SPM, '1);
            1:       plan_write(etth_pkg::CFG_SPM, DATA_W'(1));
            2:       plan_write(etth_pkg::CFG_SPM, '0);
            default: plan_write(etth_pkg::CFG_SPM, DATA_W'($urandom));
        endcase
        case ($urandom_range(0, 3))
            0:       plan_write(etth_pkg::CFG_OVR, '0);
            1:       plan_write(etth_pkg::CFG_OVR, '1);
            default: plan_write(etth_pkg::CFG_OVR, DATA_W'($urandom));
        endcase
        case ($urandom_range(0, 5))
            0:       plan_write(etth_pkg::CFG_AMP, '0);
            1:       plan_write(etth_pkg::CFG_AMP, DATA_W'(1));
            2:       plan_write(etth_pkg::CFG_AMP, DATA_W'(16'h7FFF));
            3:       plan_write(etth_pkg::CFG_AMP, '1);
            default: plan_write(etth_pkg::CFG_AMP, DATA_W'($urandom));
        endcase
        case ($urandom_range(0, 3))
            0:       plan_write(etth_pkg::CFG_SAVE, '0);
            1:       plan_write(etth_pkg::CFG_SAVE, '1);
            default: plan_write(etth_pkg::CFG_SAVE, DATA_W'($urandom));
        endcase
        if ($urandom_range(0, 2) == 0)
            plan_write(IDX_W'($urandom_range(CFG_FIRST_UNUSED, 2**IDX_W - 1)),
                       DATA_W'($urandom));
        repeat (n_words)
            plan_word(random_points());
    endtask

    always @(posedge clk) begin
        t_step step;
        logic  nxt_valid;
        logic  nxt_we;
        if (cfg_we)
            apply_register(cfg_idx, cfg_data);
        if (word_valid && !in_stall)
            expected_estimates.push_back(estimate_travel_time(in_word));
        nxt_valid = word_valid && in_stall;
        nxt_we    = 1'b0;
        if (rst_n && !nxt_valid) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (drive_plan.size() != 0) begin
                step = drive_plan[0];
                case (step.kind)
                    STEP_WORD: begin
                        nxt_valid = 1'b1;
                        in_word  <= step.word;
                        void'(drive_plan.pop_front());
                        if ($urandom_range(0, 63) == 0)
                            send_quiet = !send_quiet;
                        gap_left = send_quiet ? 0 : idle_length();
                    end
                    STEP_CFG: begin
                        nxt_we    = 1'b1;
                        cfg_idx  <= step.idx;
                        cfg_data <= step.data;
                        void'(drive_plan.pop_front());
                    end
                    STEP_DRAIN: begin
                        if (expected_estimates.size() == 0 && !word_valid) begin
                            void'(drive_plan.pop_front());
                            gap_left = SETTLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        word_valid <= nxt_valid;
        cfg_we     <= nxt_we;
    end

    always @(posedge clk) begin
        etth_pkg::t_out_word want;
        logic                nxt_stall;
        if (rst_n && res_valid && !res_stall) begin
            estimates_checked++;
            if (expected_estimates.size() == 0) begin
                $error("unexpected result word: estimate_seconds %0d, saturated %0b",
                       res_word.estimate_seconds, res_word.saturated);
                mismatch_count++;
            end else begin
                want = expected_estimates.pop_front();
                if (res_word.estimate_seconds !== want.estimate_seconds) begin
                    $error("estimate_seconds: expected %0d, got %0d",
                           want.estimate_seconds, res_word.estimate_seconds);
                    mismatch_count++;
                end
                if (res_word.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, res_word.saturated);
                    mismatch_count++;
                end
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (!hold_done && estimates_checked >= hold_start) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            nxt_stall = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            nxt_stall = 1'b1;
        end else begin
            if ($urandom_range(0, 63) == 0)
                recv_quiet = !recv_quiet;
            stall_left = recv_quiet ? 0 : idle_length();
            nxt_stall  = (stall_left != 0);
            if (nxt_stall)
                stall_left--;
        end
        res_stall <= nxt_stall;
    end

    always @(posedge clk) begin
        if ((word_valid && !in_stall) || (res_valid && !res_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $error("no word moved for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        plan_word(points('0, '0, '0, '0, '0, '0));
        plan_word(points(COORD_TOP, COORD_TOP, COORD_TOP,
                         COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM));
        plan_word(points(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM,
                         COORD_TOP, COORD_TOP, COORD_TOP));
        plan_word(points(t_coord'(3), t_coord'(4), '0, '0, '0, '0));
        plan_word(random_points());

        plan_pause();
        plan_write(etth_pkg::CFG_MODE, DATA_W'(etth_pkg::MODE_OVER));
        plan_write(etth_pkg::CFG_OVR, '1);
        plan_word(points(COORD_TOP, COORD_TOP, COORD_TOP,
                         COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM));
        plan_word(points('0, '0, '0, '0, '0, '0));
        plan_word(random_points());

        // Unused register indexes must leave the settings untouched.
        plan_pause();
        plan_write(etth_pkg::CFG_MODE, DATA_W'(etth_pkg::MODE_ZERO));
        for (int k = CFG_FIRST_UNUSED; k < 2**IDX_W; k++)
            plan_write(IDX_W'(k), '1);
        plan_word(points(COORD_TOP, COORD_TOP, COORD_TOP,
                         COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM));
        plan_word(random_points());

        // Height weighting with a zero amplitude, which acts as one.
        plan_pause();
        plan_write(etth_pkg::CFG_MODE, DATA_W'(etth_pkg::MODE_HEIGHT));
        plan_write(etth_pkg::CFG_SPM, '1);
        plan_write(etth_pkg::CFG_AMP, '0);
        plan_write(etth_pkg::CFG_SAVE, '1);
        plan_word(points('0, COORD_BOTTOM, '0, '0, '0, '0));
        plan_word(points(COORD_TOP, COORD_TOP, COORD_TOP,
                         COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM));
        plan_word(points('0, t_coord'(1), '0, t_coord'(1), t_coord'(1), '0));
        plan_word(points('0, '0, '0, t_coord'(5), '0, '0));

        // A zero rate gives no base; the amplitude write drops its top bit.
        plan_pause();
        plan_write(etth_pkg::CFG_SPM, '0);
        plan_write(etth_pkg::CFG_AMP, DATA_W'(16'h8064));
        plan_write(etth_pkg::CFG_SAVE, DATA_W'(16'h1234));
        plan_word(points('0, COORD_TOP, '0, COORD_BOTTOM, '0, '0));
        plan_word(points('0, t_coord'(100), '0, '0, '0, '0));

        plan_pause();
        plan_write(etth_pkg::CFG_MODE, DATA_W'(etth_pkg::MODE_PLAIN));
        plan_word(points(COORD_TOP, COORD_TOP, COORD_TOP,
                         COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM));

        hold_start = words_planned + 40;

        plan_random_phase(400, etth_pkg::t_mode'($urandom_range(0, 3)));
        for (int p = 0; p < 8; p++)
            plan_random_phase(130, etth_pkg::t_mode'(p % 4));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (drive_plan.size() != 0 || word_valid || expected_estimates.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/etth_pkg.sv
rtl/etth_sqrt_cell.sv
rtl/etth_div_cell.sv
rtl/euclid_travel_time_heuristic.sv
tb/tb_top.sv
